>>> design/sstree_pkg.sv
package sstree_pkg;

   // Command codes of the request channel.
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_NEXT  = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_TARGET   = 2'd0;
   localparam logic [1:0] CSR_EXCLUDED = 2'd1;
   localparam logic [1:0] CSR_COUNT    = 2'd2;
   localparam logic [1:0] CSR_START    = 2'd3;

   // Result kinds.
   localparam logic RESULT_SOLUTION = 1'b0;
   localparam logic RESULT_FINISHED = 1'b1;

   localparam int NODE_BITS = 33;
   localparam int SUM_BITS  = 29;
   localparam int CSR_BITS  = 33;

   typedef struct packed {
      logic [1:0]  command;
      logic [4:0]  load_index;
      logic [23:0] item_value;
      logic [28:0] prefix_value;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [32:0] node_id;
      logic [32:0] leaf_count;
   } rsp_type;

endpackage

>>> design/sstree_eval.sv
// Node classifier. Finds the path length of one node, then walks its path bits,
// reading one stored value per cycle, then looks up four prefix sums one per cycle
// and compares the bound interval against the missing amount.
module sstree_eval
   import sstree_pkg::*;
#(
   parameter int MAX_ITEMS  = 32,
   parameter int VALUE_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [NODE_BITS-1:0] node,
   input  logic [SUM_BITS-1:0]  target_sum,
   input  logic [5:0]           excluded_count,
   input  logic [5:0]           item_count,
   input  logic                 wr_en,
   input  logic [4:0]           wr_index,
   input  logic [23:0]          wr_value,
   input  logic [SUM_BITS-1:0]  wr_prefix,
   output logic                 done,
   output logic [1:0]           kind
);

   localparam int IDX_BITS = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_BITS = 7;
   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_EXPAND = 2'd1;
   localparam logic [1:0] KIND_PRUNE  = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LEN   = 6'b000010,
      ST_SUM   = 6'b000100,
      ST_PRE   = 6'b001000,
      ST_CMP   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   logic [VALUE_BITS-1:0] value_mem [MAX_ITEMS];
   logic [SUM_BITS-1:0]   prefix_mem [MAX_ITEMS];
   logic [VALUE_BITS-1:0] value_rd_ff;
   logic [SUM_BITS-1:0]   prefix_rd_ff;
   logic [IDX_BITS-1:0]   value_addr, prefix_addr;

   state_type state_ff, state_in;
   logic [NODE_BITS-1:0] node_ff, node_in;
   logic [CNT_BITS-1:0]  plen_ff, plen_in;      // path length
   logic [CNT_BITS-1:0]  pos_ff, pos_in;        // path position being summed
   logic [CNT_BITS-1:0]  ones_ff, ones_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 bit_ff, bit_in;
   logic [SUM_BITS+1:0]  acc_ff, acc_in;
   logic [2:0]           pstep_ff, pstep_in;
   logic [SUM_BITS:0]    pre_ff [4];
   logic [SUM_BITS:0]    pre_in [4];
   logic [1:0]           kind_ff, kind_in;

   logic [CNT_BITS-1:0] n_eff, k_ext, o_cnt, pre_idx;
   logic                pre_zero;
   logic signed [SUM_BITS+2:0] z1, z2, dd;

   // Table memories: one write port, registered read.
   always_ff @(posedge clock) begin
      if (wr_en && ({1'b0, wr_index} < 6'(MAX_ITEMS))) begin
         value_mem[wr_index[IDX_BITS-1:0]]  <= wr_value[VALUE_BITS-1:0];
         prefix_mem[wr_index[IDX_BITS-1:0]] <= wr_prefix;
      end
      value_rd_ff  <= value_mem[value_addr];
      prefix_rd_ff <= prefix_mem[prefix_addr];
   end

   assign n_eff = (item_count > 6'(MAX_ITEMS)) ? CNT_BITS'(MAX_ITEMS) : {1'b0, item_count};
   assign k_ext = {1'b0, excluded_count};
   assign o_cnt = n_eff - k_ext - ones_ff;
   assign value_addr = pos_ff[IDX_BITS-1:0];

   // Prefix index for each of the four lookups: p+o, p, n, n-o.
   always_comb begin
      case (pstep_ff)
         3'd0:    pre_idx = plen_ff + o_cnt;
         3'd1:    pre_idx = plen_ff;
         3'd2:    pre_idx = n_eff;
         default: pre_idx = n_eff - o_cnt;
      endcase
   end
   assign pre_zero = (pre_idx == '0) || (pre_idx > CNT_BITS'(MAX_ITEMS));
   assign prefix_addr = IDX_BITS'(pre_idx - 1'b1);

   assign z1 = $signed({2'b0, pre_ff[0]}) - $signed({2'b0, pre_ff[1]});
   assign z2 = $signed({2'b0, pre_ff[2]}) - $signed({2'b0, pre_ff[3]});
   assign dd = $signed({3'b0, target_sum}) - $signed({1'b0, acc_ff});

   always_comb begin
      state_in   = state_ff;
      node_in    = node_ff;
      plen_in    = plen_ff;
      pos_in     = pos_ff;
      ones_in    = ones_ff;
      rd_pend_in = 1'b0;
      bit_in     = bit_ff;
      acc_in     = acc_ff;
      pstep_in   = pstep_ff;
      pre_in     = pre_ff;
      kind_in    = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               node_in  = node;
               plen_in  = '0;
               pos_in   = '0;
               ones_in  = '0;
               acc_in   = '0;
               pstep_in = '0;
               state_in = ST_LEN;
            end
         end
         // Path length: one shift step per cycle down to the leading one.
         ST_LEN: begin
            if (node_ff[NODE_BITS-1:1] == '0 || plen_ff > n_eff) begin
               if (plen_ff > n_eff) begin
                  kind_in  = KIND_PRUNE;
                  state_in = ST_DONE;
               end else begin
                  node_in  = node;
                  state_in = ST_SUM;
               end
            end else begin
               node_in = node_ff >> 1;
               plen_in = plen_ff + 1'b1;
            end
         end
         // Sum the chosen values, one memory read per path bit.
         ST_SUM: begin
            if (rd_pend_ff && bit_ff) begin
               acc_in  = acc_ff + (SUM_BITS+2)'(value_rd_ff);
               ones_in = ones_ff + 1'b1;
            end
            if (pos_ff < plen_ff) begin
               bit_in     = node_ff[6'(plen_ff - pos_ff - 1'b1)];
               pos_in     = pos_ff + 1'b1;
               rd_pend_in = 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = ST_PRE;
            end
         end
         ST_PRE: begin
            if ((plen_ff - ones_ff) > k_ext || (ones_ff + k_ext) > n_eff) begin
               kind_in  = KIND_PRUNE;
               state_in = ST_DONE;
            end else begin
               if (rd_pend_ff) begin
                  pre_in[2'(pstep_ff - 1'b1)] = bit_ff ? '0 : {1'b0, prefix_rd_ff};
               end
               if (pstep_ff < 3'd4) begin
                  bit_in     = pre_zero;
                  rd_pend_in = 1'b1;
                  pstep_in   = pstep_ff + 1'b1;
               end else if (!rd_pend_ff) begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            if (z1 == 0 && dd == 0 && z2 == 0) kind_in = KIND_ACCEPT;
            else if (z1 <= dd && dd <= z2)     kind_in = KIND_EXPAND;
            else                               kind_in = KIND_PRUNE;
            state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
      end
      node_ff  <= node_in;
      plen_ff  <= plen_in;
      pos_ff   <= pos_in;
      ones_ff  <= ones_in;
      bit_ff   <= bit_in;
      acc_ff   <= acc_in;
      pstep_ff <= pstep_in;
      pre_ff   <= pre_in;
      kind_ff  <= kind_in;
   end

   assign done = (state_ff == ST_DONE);
   assign kind = kind_ff;

endmodule

>>> design/subset_sum_tree_search.sv
// Fixed-size subset-sum search engine. Load the sorted values and their prefix
// sums with load commands, set the registers, issue a start, then issue next
// commands; each next gives exactly one result strobe, either a solution node or
// the finished mark with the leaf count. Load and start give no result. A next
// walks the tree node by node; the node classifier reads the value table once
// per path bit of each visited node. Each leaf then folds the stack pair by pair
// (a read of the top two leaf counts, then, while both are nonzero, a write of
// their sum into the entry below them), and the next node is then fetched from
// the stack top. busy is high while a next is in progress; the result strobe is
// a single cycle and cannot be held off by the receiver.
module subset_sum_tree_search
   import sstree_pkg::*;
#(
   parameter int MAX_ITEMS   = 32,
   parameter int VALUE_BITS  = 24,
   parameter int STACK_DEPTH = 66
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_strobe,
   output rsp_type             rsp_data,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [CSR_BITS-1:0] csr_data
);

   localparam int SP_BITS = $clog2(STACK_DEPTH + 1);
   localparam int SA_BITS = $clog2(STACK_DEPTH);
   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_EXPAND = 2'd1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CHECK  = 9'b000000010,
      ST_EVAL   = 9'b000000100,
      ST_WAIT   = 9'b000001000,
      ST_FOLDRD = 9'b000010000,
      ST_FOLDCK = 9'b000100000,
      ST_TOPRD  = 9'b001000000,
      ST_TOPUSE = 9'b010000000,
      ST_REPORT = 9'b100000000
   } state_type;

   // Configuration registers.
   logic [SUM_BITS-1:0]  target_ff;
   logic [5:0]           excluded_ff, count_ff;
   logic [NODE_BITS-1:0] start_node_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         excluded_ff   <= '0;
         count_ff      <= 6'd1;
         start_node_ff <= NODE_BITS'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TARGET:   target_ff     <= csr_data[SUM_BITS-1:0];
            CSR_EXCLUDED: excluded_ff   <= csr_data[5:0];
            CSR_COUNT:    count_ff      <= csr_data[5:0];
            CSR_START:    start_node_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Stack memory: node id and leaf count per entry, registered read ports.
   logic [NODE_BITS-1:0] stk_node_mem [STACK_DEPTH];
   logic [NODE_BITS-1:0] stk_leaf_mem [STACK_DEPTH];
   logic                 stk_we;
   logic [SA_BITS-1:0]   stk_waddr, stk_ra, stk_rb;
   logic [NODE_BITS-1:0] stk_wnode, stk_wleaf;
   logic                 stk_wnode_en;
   logic [NODE_BITS-1:0] rd_node_ff, rd_leaf_a_ff, rd_leaf_b_ff;

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_leaf_mem[stk_waddr] <= stk_wleaf;
         if (stk_wnode_en) stk_node_mem[stk_waddr] <= stk_wnode;
      end
      rd_node_ff   <= stk_node_mem[stk_ra];
      rd_leaf_a_ff <= stk_leaf_mem[stk_ra];
      rd_leaf_b_ff <= stk_leaf_mem[stk_rb];
   end

   state_type state_ff, state_in;
   logic [SP_BITS-1:0]   sp_ff, sp_in;
   logic [NODE_BITS-1:0] cur_ff, cur_in;
   logic                 active_ff, active_in;
   logic [NODE_BITS-1:0] leaves_ff, leaves_in;
   logic                 base_nz_ff, base_nz_in;   // stack bottom leaf count nonzero
   logic                 accept_ff, accept_in;
   logic [NODE_BITS-1:0] hit_ff, hit_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic                 strobe_ff, strobe_in;
   logic                 eval_go, eval_done;
   logic [1:0]           eval_kind;
   logic [NODE_BITS-1:0] fold_sum;
   logic                 accepted;

   assign accepted = start && !busy;
   assign fold_sum = rd_leaf_a_ff + rd_leaf_b_ff;

   sstree_eval #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_eval (
      .clock          (clock),
      .reset          (reset),
      .go             (eval_go),
      .node           (cur_ff),
      .target_sum     (target_ff),
      .excluded_count (excluded_ff),
      .item_count     (count_ff),
      .wr_en          (accepted && req_data.command == CMD_LOAD),
      .wr_index       (req_data.load_index),
      .wr_value       (req_data.item_value),
      .wr_prefix      (req_data.prefix_value),
      .done           (eval_done),
      .kind           (eval_kind)
   );

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      cur_in       = cur_ff;
      active_in    = active_ff;
      leaves_in    = leaves_ff;
      base_nz_in   = base_nz_ff;
      accept_in    = accept_ff;
      hit_in       = hit_ff;
      rsp_kind_in  = RESULT_FINISHED;
      strobe_in    = 1'b0;
      eval_go      = 1'b0;
      stk_we       = 1'b0;
      stk_wnode_en = 1'b0;
      stk_waddr    = SA_BITS'(sp_ff);
      stk_wnode    = cur_ff;
      stk_wleaf    = '0;
      stk_ra       = SA_BITS'(sp_ff - 1'b1);
      stk_rb       = SA_BITS'(sp_ff - 2'd2);
      unique case (state_ff)
         ST_IDLE: begin
            if (accepted) begin
               unique case (req_data.command)
                  CMD_START: begin
                     sp_in      = '0;
                     leaves_in  = '0;
                     cur_in     = start_node_ff;
                     active_in  = (start_node_ff != '0);
                     base_nz_in = 1'b0;
                  end
                  CMD_NEXT: begin
                     if (active_ff) state_in = ST_CHECK;
                     else strobe_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         // Walk top: stop if the bottom entry already holds a leaf count.
         ST_CHECK: begin
            if (sp_ff != '0 && base_nz_ff) begin
               active_in = 1'b0;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               eval_go  = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: state_in = ST_WAIT;
         ST_WAIT: begin
            if (eval_done) begin
               if (sp_ff >= SP_BITS'(STACK_DEPTH)) begin
                  active_in = 1'b0;
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  stk_we       = 1'b1;
                  stk_wnode_en = 1'b1;
                  stk_wleaf    = (eval_kind == KIND_EXPAND) ? '0 : NODE_BITS'(1);
                  sp_in        = sp_ff + 1'b1;
                  if (sp_ff == '0) base_nz_in = (eval_kind != KIND_EXPAND);
                  if (eval_kind == KIND_EXPAND) begin
                     cur_in   = cur_ff << 1;
                     state_in = ST_CHECK;
                  end else begin
                     leaves_in = leaves_ff + 1'b1;
                     accept_in = (eval_kind == KIND_ACCEPT);
                     hit_in    = cur_ff;
                     state_in  = ST_FOLDRD;
                  end
               end
            end
         end
         // Fold: read the top two leaf counts.
         ST_FOLDRD: begin
            if (sp_ff > SP_BITS'(2)) state_in = ST_FOLDCK;
            else state_in = ST_TOPRD;
         end
         ST_FOLDCK: begin
            if (rd_leaf_a_ff != '0 && rd_leaf_b_ff != '0) begin
               stk_we    = 1'b1;
               stk_waddr = SA_BITS'(sp_ff - 2'd3);
               stk_wleaf = fold_sum;
               sp_in     = sp_ff - 2'd2;
               if (sp_ff == SP_BITS'(3)) base_nz_in = (fold_sum != '0);
               state_in  = ST_FOLDRD;
            end else begin
               state_in = ST_TOPRD;
            end
         end
         ST_TOPRD: state_in = ST_TOPUSE;
         ST_TOPUSE: begin
            cur_in = rd_node_ff + 1'b1;
            if (accept_ff) begin
               rsp_kind_in = RESULT_SOLUTION;
               strobe_in   = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         sp_ff      <= '0;
         cur_ff     <= NODE_BITS'(1);
         active_ff  <= 1'b0;
         leaves_ff  <= '0;
         base_nz_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sp_ff      <= sp_in;
         cur_ff     <= cur_in;
         active_ff  <= active_in;
         leaves_ff  <= leaves_in;
         base_nz_ff <= base_nz_in;
         strobe_ff  <= strobe_in;
      end
      accept_ff   <= accept_in;
      hit_ff      <= hit_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   // Result register: leaf total follows the transfer since it is stable then.
   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_strobe           = strobe_ff;
   assign rsp_data.result_kind = rsp_kind_ff;
   assign rsp_data.node_id     = (rsp_kind_ff == RESULT_SOLUTION) ? hit_ff : '0;
   assign rsp_data.leaf_count  = leaves_ff;

endmodule
